### rtl/core/ctl_pkg.sv
package ctl_pkg;

  // Limit on accepted tokens per message.
  localparam int MAX_TOKENS = 8;

  localparam int NUM_KEYWORDS = 6;
  localparam int KW_MAX_LEN = 5;

  // Character codes used by the lexer.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_F = 8'h46;
  localparam logic [7:0] CH_X     = 8'h78;

  // Token classes.
  localparam logic [1:0] TYPE_NUMBER  = 2'd0;
  localparam logic [1:0] TYPE_KEYWORD = 2'd1;
  localparam logic [1:0] TYPE_STRING  = 2'd2;

  // Keyword spellings, padded with zero bytes.
  localparam logic [0:NUM_KEYWORDS-1][0:KW_MAX_LEN-1][7:0] KW_TEXT = '{
    '{"i", "d", 8'h00, 8'h00, 8'h00},
    '{"c", "a", "l",   "i",   "b"},
    '{"g", "o", "t",   "o",   8'h00},
    '{"s", "t", "e",   "p",   8'h00},
    '{"c", "a", "l",   "c",   8'h00},
    '{"t", "i", "m",   "e",   8'h00}
  };
  localparam logic [0:NUM_KEYWORDS-1][2:0] KW_LEN = '{
    3'd2, 3'd5, 3'd4, 3'd4, 3'd4, 3'd4
  };

  // One result transaction.
  typedef struct packed {
    logic        token_present;
    logic [2:0]  token_index;
    logic [1:0]  token_type;
    logic [15:0] number_value;
    logic [2:0]  keyword_id;
    logic        end_of_message;
    logic [3:0]  tokens_found;
  } result_t;

  // True when keyword k still matches with character c at position p.
  function automatic logic kw_match(input int k, input logic [2:0] p, input logic [7:0] c);
    logic hit;
    hit = 1'b0;
    if (p < KW_LEN[k]) begin
      hit = (KW_TEXT[k][p] == c);
    end
    return hit;
  endfunction

endpackage

### rtl/core/command_token_lexer.sv
// A result is registered into the output register from the byte that ends a token.
// Throughput: one byte per cycle while in_stall is low; the per-byte update is a single registered pass.
// A two-entry output (result register plus skid register) keeps input flowing
// while one result waits; input stalls only when both entries are full.
// Reset (rst_n low, synchronous) clears the lexer state and empties the output.
module command_token_lexer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_ch,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_token_present,
  output logic [2:0]  out_token_index,
  output logic [1:0]  out_token_type,
  output logic [15:0] out_number_value,
  output logic [2:0]  out_keyword_id,
  output logic        out_end_of_message,
  output logic [3:0]  out_tokens_found
);

  // Lexer state.
  logic        in_token_r, in_token_nxt;
  logic [3:0]  count_r, count_nxt;
  logic [2:0]  pos_r, pos_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic        hex_ok_r, hex_ok_nxt;
  logic [ctl_pkg::NUM_KEYWORDS-1:0] cand_r, cand_nxt;

  // Output register and skid register.
  logic              ov_r, sv_r;
  ctl_pkg::result_t  od_r, sd_r;

  logic              accept;
  logic              is_end, is_sep;
  logic              res_valid;
  logic              out_take;
  ctl_pkg::result_t  res;

  // Working values for the byte being fed into a token.
  logic        start;
  logic [2:0]  p;
  logic [15:0] acc_b;
  logic        hex_b;
  logic [ctl_pkg::NUM_KEYWORDS-1:0] cand_b;
  logic [3:0]  digit;
  logic        digit_ok;
  logic        kw_found;
  logic        is_num;

  assign in_stall = sv_r;
  assign accept   = in_valid && !sv_r;
  assign out_take = ov_r && !out_stall;

  assign is_end    = (in_ch == ctl_pkg::CH_NUL);
  assign is_sep    = (in_ch == ctl_pkg::CH_SPACE) && in_token_r;
  assign res_valid = accept && (is_end || is_sep);

  // Classification of the token that the current byte closes.
  always_comb begin
    res = '0;
    kw_found = 1'b0;
    is_num = hex_ok_r && (pos_r >= 3'd3) && (pos_r <= 3'd6);
    if (in_token_r) begin
      res.token_present = 1'b1;
      res.token_index   = 3'(count_r - 4'd1);
      if (is_num) begin
        res.token_type   = ctl_pkg::TYPE_NUMBER;
        res.number_value = acc_r;
      end else begin
        res.token_type = ctl_pkg::TYPE_STRING;
        for (int k = ctl_pkg::NUM_KEYWORDS - 1; k >= 0; k--) begin
          if (cand_r[k] && (ctl_pkg::KW_LEN[k] == pos_r)) begin
            kw_found       = 1'b1;
            res.keyword_id = 3'(k);
          end
        end
        if (kw_found) begin
          res.token_type = ctl_pkg::TYPE_KEYWORD;
        end
      end
    end
    res.end_of_message = is_end;
    res.tokens_found   = count_r;
  end

  // Hex digit decode of the incoming byte.
  always_comb begin
    digit    = 4'd0;
    digit_ok = 1'b0;
    if ((in_ch >= ctl_pkg::CH_ZERO) && (in_ch <= ctl_pkg::CH_NINE)) begin
      digit    = 4'(in_ch - ctl_pkg::CH_ZERO);
      digit_ok = 1'b1;
    end else if ((in_ch >= ctl_pkg::CH_UPPER_A) && (in_ch <= ctl_pkg::CH_UPPER_F)) begin
      digit    = 4'(in_ch - ctl_pkg::CH_UPPER_A + 8'd10);
      digit_ok = 1'b1;
    end
  end

  // Next lexer state.
  always_comb begin
    in_token_nxt = in_token_r;
    count_nxt    = count_r;
    pos_nxt      = pos_r;
    acc_nxt      = acc_r;
    hex_ok_nxt   = hex_ok_r;
    cand_nxt     = cand_r;

    start  = !in_token_r;
    p      = start ? 3'd0 : pos_r;
    acc_b  = start ? 16'd0 : acc_r;
    hex_b  = start ? 1'b1 : hex_ok_r;
    cand_b = start ? {ctl_pkg::NUM_KEYWORDS{1'b1}} : cand_r;

    if (is_end) begin
      in_token_nxt = 1'b0;
      count_nxt    = 4'd0;
      pos_nxt      = 3'd0;
      acc_nxt      = 16'd0;
      hex_ok_nxt   = 1'b1;
      cand_nxt     = {ctl_pkg::NUM_KEYWORDS{1'b1}};
    end else if (is_sep) begin
      in_token_nxt = 1'b0;
    end else if (in_ch == ctl_pkg::CH_SPACE) begin
      in_token_nxt = in_token_r;
    end else if (start && (count_r >= 4'(ctl_pkg::MAX_TOKENS))) begin
      in_token_nxt = 1'b0;
    end else begin
      // Feed one token byte.
      in_token_nxt = 1'b1;
      if (start) begin
        count_nxt = count_r + 4'd1;
      end
      hex_ok_nxt = hex_b;
      acc_nxt    = acc_b;
      if (p == 3'd0) begin
        hex_ok_nxt = hex_b && (in_ch == ctl_pkg::CH_ZERO);
      end else if (p == 3'd1) begin
        hex_ok_nxt = hex_b && (in_ch == ctl_pkg::CH_X);
      end else if (p <= 3'd5) begin
        hex_ok_nxt = hex_b && digit_ok;
        acc_nxt    = {acc_b[11:0], digit};
      end else begin
        hex_ok_nxt = 1'b0;
      end
      for (int k = 0; k < ctl_pkg::NUM_KEYWORDS; k++) begin
        cand_nxt[k] = cand_b[k] && ctl_pkg::kw_match(k, p, in_ch);
      end
      pos_nxt = (p < 3'd7) ? p + 3'd1 : p;
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_token_r <= 1'b0;
      count_r    <= 4'd0;
      pos_r      <= 3'd0;
      acc_r      <= 16'd0;
      hex_ok_r   <= 1'b1;
      cand_r     <= {ctl_pkg::NUM_KEYWORDS{1'b1}};
    end else if (accept) begin
      in_token_r <= in_token_nxt;
      count_r    <= count_nxt;
      pos_r      <= pos_nxt;
      acc_r      <= acc_nxt;
      hex_ok_r   <= hex_ok_nxt;
      cand_r     <= cand_nxt;
    end
  end

  // Output register with skid entry; the skid fills only while the output is stalled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      sv_r <= 1'b0;
    end else if (sv_r) begin
      if (out_take) begin
        od_r <= sd_r;
        sv_r <= 1'b0;
      end
    end else if (res_valid) begin
      if (!ov_r || out_take) begin
        od_r <= res;
        ov_r <= 1'b1;
      end else begin
        sd_r <= res;
        sv_r <= 1'b1;
      end
    end else if (out_take) begin
      ov_r <= 1'b0;
    end
  end

  assign out_valid          = ov_r;
  assign out_token_present  = od_r.token_present;
  assign out_token_index    = od_r.token_index;
  assign out_token_type     = od_r.token_type;
  assign out_number_value   = od_r.number_value;
  assign out_keyword_id     = od_r.keyword_id;
  assign out_end_of_message = od_r.end_of_message;
  assign out_tokens_found   = od_r.tokens_found;

endmodule
